/* rtl/core/pol_pkg.sv */
// Shared types, codes and constants for the positional ordered list.
package pol_pkg;

    // Default list capacity and fixed field widths.
    localparam int CAPACITY_DEF = 16;
    localparam int OP_W         = 3;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 16;
    localparam int STATUS_W     = 2;
    localparam int ENTRY_W      = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_HEAD = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] STS_FULL   = 2'd3;

    // One request.
    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        logic signed [POS_W-1:0]   position;
    } req_t;

    // One response.
    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        logic [STATUS_W-1:0]       status;
        logic [ENTRY_W-1:0]        entry_count;
    } rsp_t;

endpackage

/* rtl/core/pol_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module pol_ram #(
    parameter int WIDTH = pol_pkg::VALUE_W,
    parameter int DEPTH = pol_pkg::CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/positional_ordered_list.sv */
// Top level of the bounded positional ordered list, storage held in one RAM.
//
//   Channel   Direction  Handshake              Payload
//   request   in         req_valid / req_stall  req (op, value, position)
//   response  out        rsp_valid / rsp_stall  rsp (popped_value, status, entry_count)
//
// A request that changes nothing (error status or unused op) goes straight to
// the response. An insert at index idx shifts the entries from idx up one slot,
// then writes the value; an append writes it at once. A delete or pop at position
// p shifts the entries above p down one slot. Each shift moves one entry per
// cycle through the RAM read and write ports. Reset clears the count and all
// control state; the RAM is not cleared. A finished response waits in an output
// register, so a stalled response does not stop the next request from being taken.
module positional_ordered_list #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pol_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pol_pkg::rsp_t rsp
);

    import pol_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SHIFT_UP = 5'b00010,
        ST_PLACE    = 5'b00100,
        ST_SHIFT_DN = 5'b01000,
        ST_RESULT   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]        rd_addr_q_reg, rd_addr_q_next;
    logic                 issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic                 pop_reg, pop_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [VALUE_W-1:0]   popped_reg, popped_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [VALUE_W-1:0]   wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [VALUE_W-1:0]   rd_data;

    logic                 pos_neg;
    logic [31:0]          pos_mag;
    logic [31:0]          cnt_ext;
    logic                 pos_le0;
    logic                 list_full;
    logic                 del_bad;
    logic [CW-1:0]        ins_idx;

    // List storage.
    pol_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Position checks against the current count.
    always_comb
    begin
        pos_neg   = req.position[POS_W-1];
        pos_mag   = {{(32-POS_W+1){1'b0}}, req.position[POS_W-2:0]};
        cnt_ext   = 32'(count_reg);
        pos_le0   = pos_neg || (pos_mag == 32'd0);
        list_full = (count_reg == CW'(CAPACITY));
        del_bad   = pos_neg || (pos_mag >= cnt_ext);
        if (req.op == OP_INS_HEAD)
        begin
            ins_idx = '0;
        end
        else if (req.op == OP_INS_TAIL)
        begin
            ins_idx = count_reg;
        end
        else if (pos_le0)
        begin
            ins_idx = '0;
        end
        else if (pos_mag >= cnt_ext)
        begin
            ins_idx = count_reg;
        end
        else
        begin
            ins_idx = CW'(pos_mag);
        end
    end

    // Sequencer: decode, shift entries through the RAM, then post the response.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_addr_q_next = rd_addr_q_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pop_next       = pop_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_addr        = rd_addr_q_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = rd_ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = STS_OK;
                    popped_next = '0;
                    pop_next    = 1'b0;
                    pend_next   = 1'b0;
                    value_next  = req.value;
                    unique case (req.op) inside
                        OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS:
                        begin
                            if (list_full)
                            begin
                                status_next = STS_FULL;
                                state_next  = ST_RESULT;
                            end
                            else if (ins_idx == count_reg)
                            begin
                                idx_next   = AW'(ins_idx);
                                state_next = ST_PLACE;
                            end
                            else
                            begin
                                idx_next    = AW'(ins_idx);
                                rd_ptr_next = AW'(count_reg - CW'(1));
                                issue_next  = 1'b1;
                                state_next  = ST_SHIFT_UP;
                            end
                        end
                        OP_DEL_POS:
                        begin
                            if (del_bad)
                            begin
                                status_next = STS_BADPOS;
                                state_next  = ST_RESULT;
                            end
                            else
                            begin
                                idx_next    = AW'(pos_mag);
                                rd_ptr_next = AW'(pos_mag);
                                issue_next  = 1'b1;
                                state_next  = ST_SHIFT_DN;
                            end
                        end
                        OP_POP_HEAD:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STS_EMPTY;
                                state_next  = ST_RESULT;
                            end
                            else
                            begin
                                idx_next    = '0;
                                rd_ptr_next = '0;
                                issue_next  = 1'b1;
                                pop_next    = 1'b1;
                                state_next  = ST_SHIFT_DN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_SHIFT_UP:
            begin
                // Read downward from the tail; each entry lands one slot higher.
                rd_en = issue_reg;
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_addr_q_reg + AW'(1);
                end
                if (issue_reg)
                begin
                    rd_addr_q_next = rd_ptr_reg;
                    pend_next      = 1'b1;
                    if (rd_ptr_reg == idx_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - AW'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_PLACE;
                end
            end

            ST_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = value_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_RESULT;
            end

            ST_SHIFT_DN:
            begin
                // Read upward from the removed slot; each entry lands one slot lower.
                rd_en = issue_reg;
                if (pend_reg)
                begin
                    if (rd_addr_q_reg == idx_reg)
                    begin
                        if (pop_reg)
                        begin
                            popped_next = rd_data;
                        end
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = rd_addr_q_reg - AW'(1);
                    end
                end
                if (issue_reg)
                begin
                    rd_addr_q_next = rd_ptr_reg;
                    pend_next      = 1'b1;
                    if (CW'(rd_ptr_reg) == (count_reg - CW'(1)))
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CW'(1);
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                // Move the response into the output register once it is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.popped_value = popped_reg;
                    rsp_next.status       = status_reg;
                    rsp_next.entry_count  = ENTRY_W'(count_reg);
                    rsp_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pop_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            pop_reg       <= pop_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        rd_ptr_reg    <= rd_ptr_next;
        rd_addr_q_reg <= rd_addr_q_next;
        value_reg     <= value_next;
        status_reg    <= status_next;
        popped_reg    <= popped_next;
        rsp_reg       <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/core/pol_chk.sv */
// Port-level checker for the positional ordered list, bound to the top level.
module pol_chk #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input pol_pkg::rsp_t rsp
);

    import pol_pkg::*;

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // Only a successful pop carries a nonzero value.
    a_popped_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.popped_value != '0) |-> rsp.status == STS_OK)
        else $error("popped value with error status");

    // A dropped insert reports a full list.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STS_FULL) |-> rsp.entry_count == ENTRY_W'(CAPACITY))
        else $error("full status with list not full");

    // An empty status reports an empty list.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STS_EMPTY) |-> rsp.entry_count == '0)
        else $error("empty status with entries held");

    // Requests are never taken back to back.
    a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken back to back");

endmodule

bind positional_ordered_list pol_chk #(.CAPACITY(CAPACITY)) u_pol_chk (.*);

/* test/tb.sv */
// Self-checking testbench for the bounded positional ordered list.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pol_pkg::*;

    localparam int LIST_CAP    = CAPACITY_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 2 * LIST_CAP + 20;
    localparam int CYCLE_LIMIT = 500000;

    // Op codes the block does not define; they must change nothing.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Requests waiting for the driver, and responses predicted but not yet seen.
    req_t req_backlog[$];
    rsp_t rsp_expected[$];

    // Predicted list contents, head first.
    logic signed [VALUE_W-1:0] list_vals[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  req_fire      = 1'b0;
    bit  hold_trigger  = 1'b0;
    bit  hold_done     = 1'b0;
    int  hold_left     = 0;
    int  cycle_count   = 0;
    int  fail_count    = 0;

    // Fill or drain bias of the random stream.
    bit  seg_fill = 1'b0;
    int  seg_left = 0;

    positional_ordered_list #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // Apply one request to the predicted list and return the response it causes.
    task automatic list_apply(input req_t r, output rsp_t e);
        int idx;
        int pos;
        int cnt;
        pos = int'(r.position);
        cnt = list_vals.size();
        e.popped_value = '0;
        e.status       = STS_OK;
        case (r.op) inside
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS:
            begin
                if (r.op == OP_INS_HEAD) idx = 0;
                else if (r.op == OP_INS_TAIL) idx = cnt;
                else if (pos <= 0) idx = 0;
                else if (pos > cnt) idx = cnt;
                else idx = pos;
                if (cnt >= LIST_CAP) e.status = STS_FULL;
                else list_vals.insert(idx, r.value);
            end
            OP_DEL_POS:
            begin
                if (pos < 0 || pos >= cnt) e.status = STS_BADPOS;
                else list_vals.delete(pos);
            end
            OP_POP_HEAD:
            begin
                if (cnt == 0) e.status = STS_EMPTY;
                else e.popped_value = list_vals.pop_front();
            end
            default:
            begin
            end
        endcase
        e.entry_count = ENTRY_W'(list_vals.size());
    endtask

    task automatic add_req(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value,
                           input logic signed [POS_W-1:0] position);
        req_t r;
        r.op       = op;
        r.value    = value;
        r.position = position;
        req_backlog.push_back(r);
    endtask

    // Random requests in alternating fill and drain stretches, so the list
    // regularly reaches both empty and full.
    task automatic queue_random(input int n);
        req_t r;
        int   roll;
        for (int k = 0; k < n; k++)
        begin
            if (seg_left == 0)
            begin
                seg_fill = ~seg_fill;
                seg_left = $urandom_range(60, 20);
            end
            seg_left--;

            roll = $urandom_range(99);
            if (roll < 3)
            begin
                r.op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            end
            else if ((seg_fill && roll < 78) || (!seg_fill && roll < 30))
            begin
                case ($urandom_range(2))
                    0: r.op = OP_INS_HEAD;
                    1: r.op = OP_INS_TAIL;
                    default: r.op = OP_INS_POS;
                endcase
            end
            else
            begin
                r.op = ($urandom_range(99) < 60) ? OP_DEL_POS : OP_POP_HEAD;
            end

            if ($urandom_range(15) == 0)
            begin
                case ($urandom_range(3))
                    0: r.value = 32'sh7fffffff;
                    1: r.value = 32'sh80000000;
                    2: r.value = '0;
                    default: r.value = '1;
                endcase
            end
            else
            begin
                r.value = $urandom();
            end

            roll = $urandom_range(99);
            if (roll < 10) r.position = POS_W'($urandom());
            else if (roll < 13) r.position = 16'sh7fff;
            else if (roll < 16) r.position = 16'sh8000;
            else r.position = POS_W'($urandom_range(LIST_CAP + 1) - 2);

            req_backlog.push_back(r);
        end
    endtask

    // Request driver: a payload holds until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_fire)
        begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req       <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response stall: random, or held once for a long stretch when asked.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else if (hold_trigger && !hold_done)
        begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: predict each taken request and check each taken response.
    always @(posedge clk)
    begin
        rsp_t pred;
        rsp_t exp_rsp;
        req_fire = rst_n && req_valid && !req_stall;
        if (req_fire)
        begin
            list_apply(req, pred);
            rsp_expected.push_back(pred);
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_expected.size() == 0)
            begin
                $error("response with no request outstanding: popped_value %0d status %0d count %0d",
                       rsp.popped_value, rsp.status, rsp.entry_count);
                fail_count++;
            end
            else
            begin
                exp_rsp = rsp_expected.pop_front();
                if (rsp.popped_value !== exp_rsp.popped_value)
                begin
                    $error("popped_value expected %0d actual %0d",
                           exp_rsp.popped_value, rsp.popped_value);
                    fail_count++;
                end
                if (rsp.status !== exp_rsp.status)
                begin
                    $error("status expected %0d actual %0d", exp_rsp.status, rsp.status);
                    fail_count++;
                end
                if (rsp.entry_count !== exp_rsp.entry_count)
                begin
                    $error("entry_count expected %0d actual %0d",
                           exp_rsp.entry_count, rsp.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("positional_ordered_list regression: fail");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n     = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-list errors, extreme values and positions, unused ops,
        // filling to capacity and an insert into the full list.
        add_req(OP_POP_HEAD, 32'sd77, 16'sd0);
        add_req(OP_DEL_POS, 32'sd0, 16'sd0);
        add_req(OP_INS_HEAD, 32'sh7fffffff, 16'sd0);
        add_req(OP_INS_TAIL, 32'sh80000000, 16'sd0);
        add_req(OP_INS_POS, -32'sd1, 16'sh8000);
        add_req(OP_INS_POS, 32'sd1, 16'sh7fff);
        add_req(OP_INS_POS, 32'sh55555555, 16'sd2);
        add_req(OP_UNUSED_LO, 32'sd123, 16'sd1);
        add_req(OP_UNUSED_HI, -32'sd1, -16'sd1);
        add_req(OP_DEL_POS, 32'sd0, -16'sd1);
        add_req(OP_DEL_POS, 32'sd0, 16'sh7fff);
        add_req(OP_DEL_POS, 32'sd0, 16'sd5);
        for (int k = 0; k < LIST_CAP - 5; k++)
            add_req(OP_INS_POS, 32'(k * 32'h01010101), POS_W'(k % 7));
        add_req(OP_INS_TAIL, 32'shaaaaaaaa, 16'sd0);
        add_req(OP_DEL_POS, 32'sd0, POS_W'(LIST_CAP - 1));
        add_req(OP_POP_HEAD, 32'sd0, 16'sd0);
        send_idle_pct = 16;
        recv_idle_pct = 83;
        while (req_backlog.size() != 0) @(posedge clk);

        // Random with mostly stalled responses.
        send_idle_pct = 16;
        recv_idle_pct = 83;
        queue_random(610);
        while (req_backlog.size() != 0) @(posedge clk);

        // Random with a mostly idle sender.
        send_idle_pct = 83;
        recv_idle_pct = 16;
        queue_random(610);
        while (req_backlog.size() != 0) @(posedge clk);

        // Random at full rate, with one long response hold-off partway through.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(610);
        while (req_backlog.size() > 400) @(posedge clk);
        hold_trigger = 1'b1;
        while (req_backlog.size() != 0 || req_valid) @(negedge clk);

        // Drain, then give any stray response time to show up.
        while (rsp_expected.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (fail_count == 0 && rsp_expected.size() == 0)
            $display("positional_ordered_list regression: pass");
        else
            $display("positional_ordered_list regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/pol_pkg.sv
rtl/core/pol_ram.sv
rtl/core/positional_ordered_list.sv
rtl/core/pol_chk.sv
test/tb.sv
